// File: rtl/page_framebuffer_sprite_blit_defines.svh
`ifndef PAGE_FRAMEBUFFER_SPRITE_BLIT_DEFINES_SVH
`define PAGE_FRAMEBUFFER_SPRITE_BLIT_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define PFSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define PFSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pfsb_pkg.sv
package pfsb_pkg;

  // Frame and sprite geometry (IMAGE_BYTES and IMAGES are powers of two)
  localparam int PAGES       = 8;
  localparam int COLUMNS     = 128;
  localparam int IMAGE_BYTES = 1024;
  localparam int IMAGES      = 4;

  localparam int FRM_DEPTH = PAGES * COLUMNS;
  localparam int SPR_DEPTH = IMAGES * IMAGE_BYTES;
  localparam int FRM_AW    = $clog2(FRM_DEPTH);
  localparam int SPR_AW    = $clog2(SPR_DEPTH);
  localparam int IMG_AW    = $clog2(IMAGE_BYTES);
  localparam int PG_W      = $clog2(PAGES + 1);
  localparam int COL_W     = $clog2(COLUMNS + 1);
  // image row index plus one, up to height plus the pages walked
  localparam int ROW_W     = $clog2(16 + PAGES);

  // Command queue between front and back (power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT = 3'd4;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [11:0] addr;
    logic [7:0]  value;
    logic        in_range;
  } cmd_t;

  typedef struct packed {
    logic [7:0] width;
    logic [3:0] height;
    logic [7:0] right_x;
    logic [6:0] bottom_y;
    logic [1:0] image_sel;
  } cfg_t;

endpackage

// File: rtl/pfsb_front.sv
module pfsb_front import pfsb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  value_i,
  input  logic        hold_i,
  output logic        head_valid_o,
  output cmd_t        head_o,
  input  logic        pop_i
);

  cmd_t              push_cmd;
  cmd_t              q_mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;

  // Classify the incoming word and check its address range
  always_comb begin
    push_cmd.op    = op_e'(opcode_i);
    push_cmd.addr  = address_i;
    push_cmd.value = value_i;
    case (op_e'(opcode_i))
      OP_WRITE: push_cmd.in_range = 32'(address_i) < 32'(SPR_DEPTH);
      OP_READ:  push_cmd.in_range = 32'(address_i) < 32'(FRM_DEPTH);
      default:  push_cmd.in_range = 1'b1;
    endcase
  end

  // Hold off while the queue is full or the frame is being wiped after reset
  assign in_stall_o   = hold_i | (cnt_q == QCNT_W'(QDEPTH));
  assign push         = in_valid_i & ~in_stall_o;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = q_mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the queued word
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= push_cmd;
    end
  end

endmodule

// File: rtl/pfsb_back.sv
module pfsb_back import pfsb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       head_valid_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       init_busy_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_SETUP = 3'd3;
  localparam logic [2:0] ST_DRAW  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam int PRD_W = ROW_W + 8;

  // Control state
  logic [2:0]        state_q, state_d;
  logic              init_q, init_d;
  logic [FRM_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              s1_valid_q, s1_valid_d;

  // Payload state
  logic [7:0]        out_data_q;
  logic              rd_ok_q;
  logic [COL_W-1:0]  c_q, c_start_q, c_end_q;
  logic [IMG_AW-1:0] t_q, t_start_q;
  logic [PG_W-1:0]   p_q, p_end_q;
  logic [FRM_AW-1:0] pbase_q;
  logic [ROW_W-1:0]  rowp1_q;
  logic [IMG_AW-1:0] lo_base_q, hi_base_q;
  logic [2:0]        shift_q;
  logic [SPR_AW-1:0] img_q;
  logic [FRM_AW-1:0] s1_addr_q;
  logic              s1_use_lo_q, s1_use_hi_q;
  logic [7:0]        lo_rd_q, hi_rd_q, frm_rd_q;

  // Memories
  logic [7:0] frm_mem [FRM_DEPTH];
  logic [7:0] spr_mem [SPR_DEPTH];

  // Setup geometry
  logic signed [9:0]  dx;
  logic signed [5:0]  dy;
  logic [3:0]         bfull;
  logic [COL_W-1:0]   sx, endx;
  logic [IMG_AW-1:0]  six;
  logic [PG_W-1:0]    bc, sy, endy;
  logic [ROW_W-1:0]   rowp1;
  logic [PRD_W-1:0]   prod;
  logic [FRM_AW-1:0]  pbase;
  logic               empty;

  // Walk signals
  logic               last_col, last_page, use_lo, use_hi, out_take, res_load;
  logic [7:0]         res_data, lo_m, hi_m, px;
  logic [15:0]        merged;
  logic [IMG_AW-1:0]  lo_off, hi_off;
  logic [SPR_AW-1:0]  spr_lo_addr, spr_hi_addr;
  logic               frm_we;
  logic [FRM_AW-1:0]  frm_waddr;
  logic [7:0]         frm_wdata;

  // Work out the clipped column and page ranges and the first image row
  always_comb begin
    dx    = $signed({2'b00, cfg_i.right_x}) - $signed({2'b00, cfg_i.width});
    bfull = cfg_i.bottom_y[6:3];
    dy    = $signed({2'b00, bfull}) - $signed({2'b00, cfg_i.height});

    if (dx < 0) begin
      sx  = '0;
      six = IMG_AW'(cfg_i.width - cfg_i.right_x);
    end else begin
      sx  = (int'(dx) > COLUMNS) ? COL_W'(COLUMNS) : COL_W'(dx);
      six = '0;
    end
    endx = (int'(cfg_i.right_x) > COLUMNS) ? COL_W'(COLUMNS) : COL_W'(cfg_i.right_x);

    bc   = (int'(bfull) > PAGES) ? PG_W'(PAGES) : PG_W'(bfull);
    endy = (int'(bc) >= PAGES) ? PG_W'(PAGES) : PG_W'(int'(bc) + 1);
    if (dy < 0) begin
      sy = '0;
    end else begin
      sy = (int'(dy) > PAGES) ? PG_W'(PAGES) : PG_W'(dy);
    end

    rowp1 = (int'(cfg_i.height) > int'(bc)) ? ROW_W'(int'(cfg_i.height) - int'(bc)) : '0;
    prod  = PRD_W'(rowp1) * PRD_W'(cfg_i.width);
    pbase = FRM_AW'(int'(sy) * COLUMNS);
    empty = (sx >= endx) || (sy >= endy);
  end

  // Pick the image rows that feed this page
  assign use_lo    = (rowp1_q == '0) || (int'(rowp1_q) < int'(cfg_i.height));
  assign use_hi    = (rowp1_q != '0);
  assign last_col  = (c_q + COL_W'(1)) == c_end_q;
  assign last_page = (p_q + PG_W'(1)) == p_end_q;

  // Wrap the byte offset inside the image, then add the image base
  assign lo_off      = lo_base_q + t_q;
  assign hi_off      = hi_base_q + t_q;
  assign spr_lo_addr = img_q | SPR_AW'(lo_off);
  assign spr_hi_addr = img_q | SPR_AW'(hi_off);

  // Merge the two fetched rows by the pixel offset
  assign lo_m   = s1_use_lo_q ? lo_rd_q : 8'h00;
  assign hi_m   = s1_use_hi_q ? hi_rd_q : 8'h00;
  assign merged = {lo_m, hi_m} << shift_q;
  assign px     = merged[15:8];

  // Frame write port: wipe sweep or drawn byte
  assign frm_we    = (state_q == ST_CLEAR) | s1_valid_q;
  assign frm_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : s1_addr_q;
  assign frm_wdata = (state_q == ST_CLEAR) ? 8'h00 : px;

  assign out_take = out_valid_q & ~out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) & head_valid_i & (~out_valid_q | ~out_stall_i);

  // Sequence one word at a time
  always_comb begin
    state_d    = state_q;
    init_d     = init_q;
    clr_cnt_d  = clr_cnt_q;
    s1_valid_d = 1'b0;
    res_load   = 1'b0;
    res_data   = 8'h00;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          case (head_i.op)
            OP_WRITE: res_load = 1'b1;
            OP_READ:  state_d  = ST_READ;
            OP_CLEAR: state_d  = ST_CLEAR;
            OP_DRAW:  state_d  = ST_SETUP;
            default:  state_d  = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        res_load = 1'b1;
        res_data = rd_ok_q ? frm_rd_q : 8'h00;
        state_d  = ST_IDLE;
      end
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + FRM_AW'(1);
        if (clr_cnt_q == FRM_AW'(FRM_DEPTH - 1)) begin
          clr_cnt_d = '0;
          init_d    = 1'b0;
          res_load  = ~init_q;
          state_d   = ST_IDLE;
        end
      end
      ST_SETUP: begin
        state_d = empty ? ST_DONE : ST_DRAW;
      end
      ST_DRAW: begin
        s1_valid_d = 1'b1;
        if (last_col && last_page) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        res_load = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result slot: load on finish, drop when taken
  always_comb begin
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      init_q      <= 1'b1;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      s1_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      s1_valid_q  <= s1_valid_d;
    end
  end

  // Result data and read range flag
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_data_q <= res_data;
    end
    if (pop_o) begin
      rd_ok_q <= head_i.in_range;
    end
  end

  // Draw setup, then step columns and pages
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SETUP) begin
      c_q       <= sx;
      c_start_q <= sx;
      c_end_q   <= endx;
      t_q       <= six;
      t_start_q <= six;
      p_q       <= sy;
      p_end_q   <= endy;
      pbase_q   <= pbase;
      rowp1_q   <= rowp1;
      lo_base_q <= IMG_AW'(prod);
      hi_base_q <= IMG_AW'(prod) - IMG_AW'(cfg_i.width);
      shift_q   <= cfg_i.bottom_y[2:0];
      img_q     <= SPR_AW'((int'(cfg_i.image_sel) % IMAGES) * IMAGE_BYTES);
    end else if (state_q == ST_DRAW) begin
      s1_addr_q   <= pbase_q + FRM_AW'(c_q);
      s1_use_lo_q <= use_lo;
      s1_use_hi_q <= use_hi;
      if (last_col) begin
        c_q       <= c_start_q;
        t_q       <= t_start_q;
        p_q       <= p_q + PG_W'(1);
        pbase_q   <= pbase_q + FRM_AW'(COLUMNS);
        rowp1_q   <= rowp1_q + ROW_W'(1);
        hi_base_q <= lo_base_q;
        lo_base_q <= lo_base_q + IMG_AW'(cfg_i.width);
      end else begin
        c_q <= c_q + COL_W'(1);
        t_q <= t_q + IMG_AW'(1);
      end
    end
  end

  // Sprite store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.op == OP_WRITE && head_i.in_range) begin
      spr_mem[SPR_AW'(head_i.addr)] <= head_i.value;
    end
    lo_rd_q <= spr_mem[spr_lo_addr];
    hi_rd_q <= spr_mem[spr_hi_addr];
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (frm_we) begin
      frm_mem[frm_waddr] <= frm_wdata;
    end
    frm_rd_q <= frm_mem[FRM_AW'(head_i.addr)];
  end

  assign init_busy_o = init_q;
  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

endmodule

// File: rtl/page_framebuffer_sprite_blit.sv
// Each input word gives one result word. A sprite write is answered from the idle state,
// a frame read passes through the read state, a clear sweeps every frame byte, and a draw
// steps through setup, draw (one byte per clipped column on each clipped page) and done.
// The back end takes one word at a time and writes one frame byte per cycle, bound by the frame store write port.
// Reset: asynchronous, active low; the frame store is then wiped with in_stall_o
// high. Registers return to width 8, height 1, all others zero.
module page_framebuffer_sprite_blit import pfsb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic [11:0]          address_i,
  input  logic [7:0]           value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           read_data_o
);

  cfg_t cfg_q;
  cmd_t head;
  logic head_valid;
  logic pop;
  logic init_busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width     <= 8'd8;
      cfg_q.height    <= 4'd1;
      cfg_q.right_x   <= '0;
      cfg_q.bottom_y  <= '0;
      cfg_q.image_sel <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WIDTH:  cfg_q.width     <= cfg_data_i;
        CFG_HEIGHT: cfg_q.height    <= cfg_data_i[3:0];
        CFG_RIGHT:  cfg_q.right_x   <= cfg_data_i;
        CFG_BOTTOM: cfg_q.bottom_y  <= cfg_data_i[6:0];
        CFG_SELECT: cfg_q.image_sel <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  pfsb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .address_i    (address_i),
    .value_i      (value_i),
    .hold_i       (init_busy),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  pfsb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .init_busy_o  (init_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o)
  );

endmodule

// File: rtl/pfsb_checker.sv
`include "page_framebuffer_sprite_blit_defines.svh"

module pfsb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o
);

  logic [2:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;

  // Track words accepted but not yet answered
  always_comb begin
    case ({in_acc, out_acc})
      2'b10:   pend_d = pend_q + 3'd1;
      2'b01:   pend_d = pend_q - 3'd1;
      default: pend_d = pend_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `PFSB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(read_data_o), "stalled result word changed")
  `PFSB_ASSERT_NOW(a_no_extra_result, out_valid_o, pend_q != 3'd0, "result word with no word pending")
  `PFSB_ASSERT_NOW(a_pend_bound, in_valid_i || out_valid_o || !in_valid_i, pend_q <= 3'd3, "more words in flight than queue and back end hold")

endmodule

bind page_framebuffer_sprite_blit pfsb_checker u_pfsb_checker (.*);

// File: tb/tb_page_framebuffer_sprite_blit.sv
`timescale 1ns / 100ps

module tb_page_framebuffer_sprite_blit;
  import pfsb_pkg::*;

  localparam int TOTAL_WORDS   = 450;
  localparam int QUIET_TAIL    = 60;
  localparam int SETTLE_CYCLES = 1100;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_LIMIT  = 10;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_WIDTH;
  logic [7:0]           cfg_data_i  = 8'h00;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           opcode_i    = OP_READ;
  logic [11:0]          address_i   = 12'h000;
  logic [7:0]           value_i     = 8'h00;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [7:0]           read_data_o;

  page_framebuffer_sprite_blit uut (.*);

  // One pending answer per accepted word
  typedef struct {
    op_e        op;
    logic [7:0] data;
  } answer_t;

  typedef struct {
    bit          is_cfg;
    op_e         op;
    logic [11:0] addr;
    logic [7:0]  value;
    bit          zero_known;
    cfg_t        cfg;
  } script_row_t;

  answer_t     pending_answers[$];
  script_row_t script[$];
  logic [11:0] missing_sprite[$];

  // Shadow copy of the frame, the sprite images and the registers
  bit [7:0] frame_mem    [FRM_DEPTH];
  bit [7:0] sprite_mem   [SPR_DEPTH];
  bit       sprite_known [SPR_DEPTH];
  cfg_t     settings;
  int       blit_p0 = 0, blit_p1 = 0, blit_c0 = 0, blit_c1 = 0;

  bit in_gaps     = 1'b0;
  bit out_gaps    = 1'b0;
  int hold_cycles = 0;

  int failures       = 0;
  int results_seen   = 0;
  int words_sent     = 0;
  int random_words   = 0;
  int draws_sent     = 0;
  int reads_sent     = 0;
  int clears_sent    = 0;
  int writes_sent    = 0;
  int preload_writes = 0;
  int settings_count = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("page_framebuffer_sprite_blit test failed");
    $finish;
  end

  // Walk the clipped draw window; either paint the frame or list unwritten sprite bytes
  function automatic void walk_blit(input bit commit);
    int w, h, x, off, bfull, bc, endx, sx, six, endy, sy, row, base, t, p, c, a1, a2;
    logic [31:0] v;
    w     = int'(settings.width);
    h     = int'(settings.height);
    x     = int'(settings.right_x);
    off   = int'(settings.bottom_y[2:0]);
    bfull = int'(settings.bottom_y) >> 3;
    bc    = (bfull > PAGES) ? PAGES : bfull;
    endx  = (x > COLUMNS) ? COLUMNS : x;
    sx    = x - w;
    six   = w - x;
    endy  = bc + 1;
    sy    = bfull - h;
    row   = h - bc - 1;
    base  = (int'(settings.image_sel) % IMAGES) * IMAGE_BYTES;
    if (sx < 0) sx = 0;
    if (sx > COLUMNS) sx = COLUMNS;
    if (six < 0) six = 0;
    if (endy > PAGES) endy = PAGES;
    if (sy < 0) sy = 0;
    if (sy > PAGES) sy = PAGES;
    if (row < 0) row = -1;
    if (commit) begin
      blit_p0 = sy;
      blit_p1 = endy;
      blit_c0 = sx;
      blit_c1 = endx;
    end
    for (p = sy; p < endy; p++) begin
      t = six;
      for (c = sx; c < endx; c++) begin
        if (row == -1) begin
          // top page: first image row pushed down by the pixel offset
          a1 = base + (t % IMAGE_BYTES);
          a2 = a1;
          v  = ({24'd0, sprite_mem[a1]} << off) & 32'hFF;
        end else if (row < h - 1) begin
          // middle page: merge two adjacent image rows
          a1 = base + (((row + 1) * w + t) % IMAGE_BYTES);
          a2 = base + ((row * w + t) % IMAGE_BYTES);
          v  = (({24'd0, sprite_mem[a1]} << off) |
                ({24'd0, sprite_mem[a2]} >> (8 - off))) & 32'hFF;
        end else begin
          // bottom page: spill of the last row, empty when aligned
          a1 = base + ((row * w + t) % IMAGE_BYTES);
          a2 = a1;
          v  = {24'd0, sprite_mem[a1]} >> (8 - off);
        end
        if (commit) begin
          frame_mem[p * COLUMNS + c] = v[7:0];
        end else begin
          if (!sprite_known[a1]) missing_sprite.push_back(a1[11:0]);
          if (!sprite_known[a2]) missing_sprite.push_back(a2[11:0]);
        end
        t++;
      end
      row++;
    end
  endfunction

  // Update the shadow for one accepted word and return its read_data
  function automatic logic [7:0] predict_read_data(input op_e op, input logic [11:0] addr,
                                                   input logic [7:0] val);
    logic [7:0] rd;
    rd = 8'h00;
    case (op)
      OP_WRITE: begin
        if (addr < SPR_DEPTH) begin
          sprite_mem[addr]   = val;
          sprite_known[addr] = 1'b1;
        end
      end
      OP_DRAW: walk_blit(1'b1);
      OP_READ: begin
        if (addr < FRM_DEPTH) rd = frame_mem[addr];
      end
      OP_CLEAR: begin
        foreach (frame_mem[i]) frame_mem[i] = 8'h00;
      end
    endcase
    return rd;
  endfunction

  function automatic void add_word(input op_e op, input logic [11:0] addr,
                                   input logic [7:0] value, input bit zero_known);
    script_row_t r;
    r.is_cfg     = 1'b0;
    r.op         = op;
    r.addr       = addr;
    r.value      = value;
    r.zero_known = zero_known;
    r.cfg        = '0;
    script.push_back(r);
  endfunction

  function automatic void add_settings(input logic [7:0] w, input logic [3:0] h,
                                       input logic [7:0] x, input logic [6:0] y,
                                       input logic [1:0] sel);
    script_row_t r;
    r.is_cfg     = 1'b1;
    r.op         = OP_READ;
    r.addr       = 12'h000;
    r.value      = 8'h00;
    r.zero_known = 1'b0;
    r.cfg        = {w, h, x, y, sel};
    script.push_back(r);
  endfunction

  // Offer one word, hold it until accepted, then record its answer
  task automatic send_word(input op_e op, input logic [11:0] addr, input logic [7:0] val,
                           input bit zero_known);
    answer_t a;
    @(negedge clk_i);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    address_i  <= addr;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    a.op   = op;
    a.data = predict_read_data(op, addr, val);
    if (zero_known) a.data = 8'h00;
    pending_answers.push_back(a);
    words_sent++;
    case (op)
      OP_WRITE: writes_sent++;
      OP_DRAW:  draws_sent++;
      OP_READ:  reads_sent++;
      OP_CLEAR: clears_sent++;
    endcase
  endtask

  // Before a draw, write every sprite byte it will fetch that was never written
  task automatic issue(input op_e op, input logic [11:0] addr, input logic [7:0] val,
                       input bit zero_known);
    logic [11:0] a;
    if (op == OP_DRAW) begin
      missing_sprite.delete();
      walk_blit(1'b0);
      while (missing_sprite.size() != 0) begin
        a = missing_sprite.pop_front();
        if (!sprite_known[a]) begin
          send_word(OP_WRITE, a, 8'($urandom), 1'b1);
          preload_writes++;
        end
      end
    end
    send_word(op, addr, val, zero_known);
  endtask

  // Drop valid and wait for every answer
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t s);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [7:0]           data [5];
    int                   i;
    idx[0]  = CFG_WIDTH;
    idx[1]  = CFG_HEIGHT;
    idx[2]  = CFG_RIGHT;
    idx[3]  = CFG_BOTTOM;
    idx[4]  = CFG_SELECT;
    data[0] = s.width;
    data[1] = {4'd0, s.height};
    data[2] = s.right_x;
    data[3] = {1'b0, s.bottom_y};
    data[4] = {6'd0, s.image_sel};
    for (i = 0; i < 5; i++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= data[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings = s;
    settings_count++;
  endtask

  // Output stall: random bursts, or a long hold when requested
  initial begin : stall_driver
    int burst_left;
    burst_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else if (burst_left > 0) begin
        out_stall_i <= 1'b1;
        burst_left--;
      end else if (out_gaps && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        burst_left = $urandom_range(1, 6) - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each accepted output word with the oldest pending answer
  initial begin : answer_check
    answer_t a;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_answers.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("[%0t] read_data %02h arrived with no word outstanding",
                     $time, read_data_o);
        end else begin
          a = pending_answers.pop_front();
          results_seen++;
          if (read_data_o !== a.data) begin
            failures++;
            if (failures <= REPORT_LIMIT)
              $display("[%0t] %s: read_data expected %02h, got %02h",
                       $time, a.op.name(), a.data, read_data_o);
          end
        end
      end
    end
  end

  initial begin : stimulus
    cfg_t s;
    int   phase, n, k, r, p, c;
    settings           = '0;
    settings.width     = 8'd8;
    settings.height    = 4'd1;

    // Directed rows: empty frame, address extremes, value extremes, clipping,
    // zero and maximum sizes, every image, clear
    add_word(OP_READ,  12'd0,    8'h00, 1'b1);
    add_word(OP_READ,  12'd1023, 8'h00, 1'b1);
    add_word(OP_READ,  12'd4095, 8'hFF, 1'b1);
    add_word(OP_WRITE, 12'd0,    8'hFF, 1'b1);
    add_word(OP_WRITE, 12'd4095, 8'h00, 1'b1);
    add_word(OP_DRAW,  12'd0,    8'h00, 1'b1);
    add_word(OP_READ,  12'd0,    8'h00, 1'b1);
    add_settings(8'd8, 4'd1, 8'd8, 7'd7, 2'd0);
    add_word(OP_DRAW,  12'd0,    8'h00, 1'b1);
    add_word(OP_READ,  12'd0,    8'h00, 1'b0);
    add_word(OP_READ,  12'd7,    8'h00, 1'b0);
    add_settings(8'd3, 4'd2, 8'd130, 7'd13, 2'd1);
    add_word(OP_DRAW,  12'd0,    8'h00, 1'b1);
    add_word(OP_READ,  12'd127,  8'h00, 1'b0);
    add_word(OP_READ,  12'd255,  8'h00, 1'b0);
    add_settings(8'd128, 4'd8, 8'd128, 7'd127, 2'd3);
    add_word(OP_DRAW,  12'd0,    8'h00, 1'b1);
    add_word(OP_READ,  12'd896,  8'h00, 1'b0);
    add_word(OP_READ,  12'd1023, 8'h00, 1'b0);
    add_settings(8'd0, 4'd0, 8'd255, 7'd64, 2'd2);
    add_word(OP_DRAW,  12'd0,    8'h00, 1'b1);
    add_word(OP_READ,  12'd1023, 8'h00, 1'b0);
    add_settings(8'd255, 4'd15, 8'd12, 7'd43, 2'd1);
    add_word(OP_DRAW,  12'd0,    8'h00, 1'b1);
    add_word(OP_READ,  12'd650,  8'h00, 1'b0);
    add_word(OP_CLEAR, 12'd0,    8'h00, 1'b1);
    add_word(OP_READ,  12'd1023, 8'h00, 1'b1);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Let the post-reset frame wipe finish
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);

    in_gaps  = 1'b1;
    out_gaps = 1'b1;
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain();
        load_settings(script[i].cfg);
      end else begin
        issue(script[i].op, script[i].addr, script[i].value, script[i].zero_known);
      end
    end

    // Random phases: new settings, then writes, draws, clears and reads, many aimed at the drawn window
    phase = 0;
    while (words_sent < TOTAL_WORDS) begin
      drain();
      r = $urandom_range(0, 9);
      if (r < 7) begin
        s.width   = 8'($urandom_range(1, 16));
        s.right_x = 8'($urandom);
      end else begin
        // wide image near the left edge, so only its right end shows
        s.width   = 8'($urandom_range(17, 255));
        s.right_x = 8'($urandom_range(0, 8));
      end
      s.height    = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 3));
      s.bottom_y  = 7'($urandom);
      s.image_sel = 2'($urandom);
      load_settings(s);

      in_gaps  = (phase % 3 != 2) && (words_sent < TOTAL_WORDS - QUIET_TAIL);
      out_gaps = (phase % 4 != 3) && (words_sent < TOTAL_WORDS - QUIET_TAIL);
      // hold the output long enough to back the block up
      if (phase == 0) hold_cycles = HOLD_CYCLES;

      n = $urandom_range(8, 20);
      for (k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          issue(OP_WRITE, 12'($urandom), 8'($urandom), 1'b0);
        end else if (r < 40) begin
          issue(OP_DRAW, 12'($urandom), 8'($urandom), 1'b0);
        end else if (r < 85) begin
          if (blit_p0 < blit_p1 && blit_c0 < blit_c1 && $urandom_range(0, 3) != 0) begin
            p = $urandom_range(blit_p0, blit_p1 - 1);
            c = $urandom_range(blit_c0, blit_c1 - 1);
            issue(OP_READ, 12'(p * COLUMNS + c), 8'($urandom), 1'b0);
          end else begin
            issue(OP_READ, 12'($urandom), 8'($urandom), 1'b0);
          end
        end else if (r < 89) begin
          issue(OP_CLEAR, 12'($urandom), 8'($urandom), 1'b0);
        end else begin
          issue(op_e'($urandom_range(0, 3)), 12'($urandom), 8'($urandom), 1'b0);
        end
        random_words++;
      end
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Coverage: %0d words (%0d random), %0d draws, %0d frame reads, %0d clears",
             words_sent, random_words, draws_sent, reads_sent, clears_sent);
    $display("Coverage: %0d sprite writes (%0d preload), %0d register settings, %0d checked",
             writes_sent, preload_writes, settings_count, results_seen);
    if (failures == 0 && pending_answers.size() == 0) begin
      $display("page_framebuffer_sprite_blit test passed");
    end else begin
      $display("page_framebuffer_sprite_blit test failed");
    end
    $finish;
  end

endmodule
